// ===== design/trimmed_mean_window_macros.svh =====
// Assertion macros shared by the trimmed mean window RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TRIMMED_MEAN_WINDOW_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define TMW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TMW_ASSERT(lbl, prop, msg)
`define TMW_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/tmw_pkg.sv =====
// Package for the trimmed mean window: widths, status codes, job record, back-end states.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tmw_pkg;

  localparam int unsigned WindowDefault = 10;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned SumW          = 20;
  localparam int unsigned CntW          = 4;
  localparam int unsigned FracW         = 8;
  localparam int unsigned MeanW         = 24;
  localparam int unsigned NumW          = 22;
  localparam int unsigned DivW          = NumW + FracW;
  localparam int unsigned DivCntW       = $clog2(DivW);
  localparam int unsigned QDepth        = 2;

  typedef enum logic [1:0] {
    STAT_NORMAL = 2'd0,
    STAT_EQUAL  = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                    kind;
    logic signed [SumW-1:0]     sum;
    logic signed [SampleW-1:0]  max_val;
    logic signed [SampleW-1:0]  min_val;
    logic [CntW-1:0]            max_cnt;
    logic [CntW-1:0]            min_cnt;
    logic [CntW-1:0]            mid_cnt;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_NUM,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic load_num;
    logic div_step;
    logic load_out;
  } back_ctrl_t;

endpackage

// ===== design/tmw_front.sv =====
// Front end: accumulates sum, extremes and their counts per window, classifies the window.
// Depends on tmw_pkg.
`timescale 1ns / 1ps
`include "trimmed_mean_window_macros.svh"
module tmw_front import tmw_pkg::*; #(
  parameter int unsigned WINDOW = WindowDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic signed [SampleW-1:0]  sample,
  output logic                       push,
  output job_t                       job
);

  localparam logic [CntW-1:0] WinCnt = CntW'(WINDOW);

  logic [CntW-1:0]           seen_r, seen_nxt;
  logic signed [SumW-1:0]    sum_r, sum_nxt;
  logic signed [SampleW-1:0] max_r, max_nxt, min_r, min_nxt;
  logic [CntW-1:0]           maxc_r, maxc_nxt, minc_r, minc_nxt;
  logic [CntW:0]             ext_total;
  logic                      last;

  // Update the running statistics with the incoming sample.
  always_comb begin
    if (seen_r == '0) begin
      max_nxt  = sample;
      min_nxt  = sample;
      maxc_nxt = CntW'(1);
      minc_nxt = CntW'(1);
      sum_nxt  = SumW'(sample);
    end else begin
      max_nxt  = max_r;
      maxc_nxt = maxc_r;
      min_nxt  = min_r;
      minc_nxt = minc_r;
      if (sample > max_r) begin
        max_nxt  = sample;
        maxc_nxt = CntW'(1);
      end else if (sample == max_r) begin
        maxc_nxt = maxc_r + CntW'(1);
      end
      if (sample < min_r) begin
        min_nxt  = sample;
        minc_nxt = CntW'(1);
      end else if (sample == min_r) begin
        minc_nxt = minc_r + CntW'(1);
      end
      sum_nxt = sum_r + SumW'(sample);
    end
    seen_nxt = seen_r + CntW'(1);
  end

  assign last = (seen_nxt == WinCnt);
  assign push = accept && last;
  assign ext_total = {1'b0, maxc_nxt} + {1'b0, minc_nxt};

  // Classify the finished window.
  always_comb begin
    job.sum     = sum_nxt;
    job.max_val = max_nxt;
    job.min_val = min_nxt;
    job.max_cnt = maxc_nxt;
    job.min_cnt = minc_nxt;
    job.mid_cnt = WinCnt - maxc_nxt - minc_nxt;
    if (max_nxt == min_nxt) begin
      job.kind = STAT_EQUAL;
    end else if (ext_total >= {1'b0, WinCnt}) begin
      job.kind = STAT_EMPTY;
    end else begin
      job.kind = STAT_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      maxc_r <= '0;
      minc_r <= '0;
    end else if (accept) begin
      if (last) begin
        seen_r <= '0;
        maxc_r <= '0;
        minc_r <= '0;
      end else begin
        seen_r <= seen_nxt;
        maxc_r <= maxc_nxt;
        minc_r <= minc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  `TMW_ASSERT(a_seen_in_window, seen_r < WinCnt, "sample counter ran past the window")

endmodule

// ===== design/tmw_queue.sv =====
// Short job queue between front and back end, held in registers.
// Depends on tmw_pkg.
`timescale 1ns / 1ps
`include "trimmed_mean_window_macros.svh"
module tmw_queue import tmw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int unsigned PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CountW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0]   LastPtr  = PtrW'(QDepth - 1);
  localparam logic [CountW-1:0] FullCnt  = CountW'(QDepth);

  job_t              entry_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r;

  assign full   = (count_r == FullCnt);
  assign empty  = (count_r == '0);
  assign rd_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CountW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CountW'(1);
      end
    end
  end

  `TMW_NEVER(a_push_full, push && full, "job pushed into a full queue")
  `TMW_NEVER(a_pop_empty, pop && empty, "job popped from an empty queue")

endmodule

// ===== design/tmw_back.sv =====
// Back end: forms the trimmed numerator, divides by the middle count bit-serially,
// and holds the result in the output register. Depends on tmw_pkg.
`timescale 1ns / 1ps
`include "trimmed_mean_window_macros.svh"
module tmw_back import tmw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  job_t                     q_job,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MeanW-1:0]  out_mean,
  output status_t                  out_status
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivW - 1);

  back_state_t              state_r, state_nxt;
  back_ctrl_t               ctrl;
  job_t                     job_r;
  logic                     neg_r;
  logic [CntW-1:0]          rem_r;
  logic [DivW-1:0]          dq_r;
  logic [DivCntW-1:0]       step_r;
  logic                     out_valid_r;
  logic signed [MeanW-1:0]  out_mean_r;
  status_t                  out_status_r;

  logic signed [NumW-1:0]   sum_ext, max_ext, min_ext, maxc_ext, minc_ext, num;
  logic [NumW-1:0]          mag;
  logic [CntW:0]            rem_sh, rem_sub;
  logic                     ge;
  logic [DivW-1:0]          quot;
  logic signed [MeanW-1:0]  mean_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_job.kind == STAT_NORMAL) ? B_NUM : B_DONE;
        end
      end
      B_NUM:  state_nxt = B_DIV;
      B_DIV: begin
        if (step_r == LastStep) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    case (state_r)
      B_IDLE:  ctrl.pop      = !q_empty;
      B_NUM:   ctrl.load_num = 1'b1;
      B_DIV:   ctrl.div_step = 1'b1;
      B_DONE:  ctrl.load_out = !out_valid_r || out_ready;
      default: ctrl = '0;
    endcase
  end

  assign q_pop = ctrl.pop;

  // Numerator: sum less every copy of the extremes.
  always_comb begin
    sum_ext  = NumW'(job_r.sum);
    max_ext  = NumW'(job_r.max_val);
    min_ext  = NumW'(job_r.min_val);
    maxc_ext = $signed({{(NumW-CntW){1'b0}}, job_r.max_cnt});
    minc_ext = $signed({{(NumW-CntW){1'b0}}, job_r.min_cnt});
    num      = sum_ext - maxc_ext * max_ext - minc_ext * min_ext;
    mag      = num[NumW-1] ? NumW'(-num) : NumW'(num);
  end

  // One restoring division step per cycle.
  assign rem_sh  = {rem_r, dq_r[DivW-1]};
  assign ge      = (rem_sh >= {1'b0, job_r.mid_cnt});
  assign rem_sub = rem_sh - {1'b0, job_r.mid_cnt};

  // Final signed mean, truncated toward zero.
  always_comb begin
    quot = neg_r ? DivW'(-dq_r) : dq_r;
    case (job_r.kind)
      STAT_EQUAL:  mean_nxt = {job_r.max_val, {FracW{1'b0}}};
      STAT_EMPTY:  mean_nxt = '0;
      STAT_NORMAL: mean_nxt = quot[MeanW-1:0];
      default:     mean_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      job_r <= q_job;
    end
    if (ctrl.load_num) begin
      neg_r  <= num[NumW-1];
      dq_r   <= {mag, {FracW{1'b0}}};
      rem_r  <= '0;
      step_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r  <= ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      dq_r   <= {dq_r[DivW-2:0], ge};
      step_r <= step_r + DivCntW'(1);
    end
    if (ctrl.load_out) begin
      out_mean_r   <= mean_nxt;
      out_status_r <= job_r.kind;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_mean   = out_mean_r;
  assign out_status = out_status_r;

  `TMW_ASSERT(a_rem_below_div, (state_r == B_DIV) |-> (rem_r < job_r.mid_cnt),
              "division remainder not below the middle count")
  `TMW_ASSERT(a_div_nonzero, (state_r == B_NUM) |-> (job_r.mid_cnt != '0),
              "division started with no middle samples")
  `TMW_ASSERT(a_empty_zero, (out_valid_r && out_status_r == STAT_EMPTY) |-> (out_mean_r == '0),
              "empty window gave a nonzero mean")

endmodule

// ===== design/trimmed_mean_window.sv =====
// Trimmed (Olympic) mean over windows of WINDOW signed samples.
// Flow: a window's job goes through the queue, then B_NUM, B_DIV and B_DONE for a normal window,
//   or straight to B_DONE when all samples are equal or no middle samples remain.
// Throughput: one sample per cycle into the front end while the job queue has room; the back end's
//   bit-serial divider (one quotient bit per cycle, 30 bits) takes one window at a time.
// Reset: synchronous, active low rst_n; clears window counters, queue and output valid.
`timescale 1ns / 1ps
module trimmed_mean_window import tmw_pkg::*; #(
  parameter int unsigned WINDOW = WindowDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample (signed)
  // Result stream, one transfer per window
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] mean_value (signed, 8 fraction bits)
  output logic [1:0]  out_tuser   // [1:0] status: normal, all equal, no middle samples
);

  logic                     in_accept;
  logic                     push;
  job_t                     front_job;
  job_t                     q_job;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  logic signed [MeanW-1:0]  mean;
  status_t                  status;

  // Hold samples off only while the job queue has no room for a finished window.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  // Front end: fold each sample into the window statistics, push a job at window end.
  tmw_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .sample ($signed(in_tdata)),
    .push   (push),
    .job    (front_job)
  );

  // Decouple the two halves so sampling continues while a division runs.
  tmw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (front_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: numerator, serial divide, output register.
  tmw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_mean   (mean),
    .out_status (status)
  );

  assign out_tdata = mean;
  assign out_tuser = status;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for trimmed_mean_window: streams sample windows and checks each
// trimmed mean and status against an in-bench predictor. Depends on tmw_pkg and the RTL only.
`timescale 1ns / 1ps
module testbench;
  import tmw_pkg::*;

  localparam int unsigned Window        = WindowDefault;
  localparam int          RandomWindows = 185;
  // Longest back-end latency (divider plus pipeline) with some margin.
  localparam int          SettleCycles  = DivW + 12;

  typedef logic signed [SampleW-1:0] sample_t;

  localparam sample_t SampleMax = sample_t'(16'h7FFF);
  localparam sample_t SampleMin = sample_t'(16'h8000);

  typedef struct {
    logic [MeanW-1:0] mean;
    status_t          status;
  } window_result_t;

  // Tracks the open window the same way the block does (sum, extremes and their counts)
  // and queues the trimmed mean of each closed window until the block delivers it.
  class window_mean_checker;
    window_result_t         expected_means[$];
    int                     errors;
    logic signed [SumW-1:0] sum;
    sample_t                hi, lo;
    logic [CntW-1:0]        hi_cnt, lo_cnt, seen;

    function new();
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      sum    = '0;
      hi     = '0;
      lo     = '0;
      hi_cnt = '0;
      lo_cnt = '0;
      seen   = '0;
    endfunction

    function int outstanding();
      return expected_means.size();
    endfunction

    // Fold one accepted sample into the window; close the window on its last sample.
    function void take_sample(logic [SampleW-1:0] raw);
      sample_t         x;
      window_result_t  r;
      logic [CntW-1:0] mid;
      longint          num;
      x = raw;
      if (seen == 0) begin
        hi     = x;
        lo     = x;
        hi_cnt = 1;
        lo_cnt = 1;
        sum    = x;
      end else begin
        if (x > hi) begin
          hi     = x;
          hi_cnt = 1;
        end else if (x == hi) begin
          hi_cnt = hi_cnt + 1'b1;
        end
        if (x < lo) begin
          lo     = x;
          lo_cnt = 1;
        end else if (x == lo) begin
          lo_cnt = lo_cnt + 1'b1;
        end
        sum = sum + x;
      end
      seen = seen + 1'b1;
      if (seen < Window) return;

      if (hi == lo) begin
        // Flat window: the value itself, scaled to 8 fraction bits.
        r.mean   = MeanW'(longint'(hi) * 256);
        r.status = STAT_EQUAL;
      end else if (int'(hi_cnt) + int'(lo_cnt) >= Window) begin
        // Only extremes in the window: nothing left to average.
        r.mean   = '0;
        r.status = STAT_EMPTY;
      end else begin
        mid = CntW'(Window - hi_cnt - lo_cnt);
        num = longint'(sum) - longint'(hi_cnt) * longint'(hi) - longint'(lo_cnt) * longint'(lo);
        // Signed division truncates toward zero, as the block must.
        r.mean   = MeanW'((num * 256) / longint'(mid));
        r.status = STAT_NORMAL;
      end
      expected_means.push_back(r);
      clear_window();
    endfunction

    function void check_result(logic [MeanW-1:0] mean, logic [1:0] status);
      window_result_t r;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, actual mean_value %h status %0d", $time, mean, status);
        errors++;
        return;
      end
      r = expected_means.pop_front();
      if (mean !== r.mean) begin
        $display("%0t: mean_value mismatch, expected %h, actual %h", $time, r.mean, mean);
        errors++;
      end
      if (status !== r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [SampleW-1:0] in_tdata  = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [MeanW-1:0]   out_tdata;
  logic [1:0]         out_tuser;

  window_mean_checker trim_board;
  sample_t            window_buf[$];
  bit                 quiet_in  = 1'b0;  // sender runs back to back while set
  bit                 quiet_out = 1'b0;  // receiver never stalls while set

  trimmed_mean_window i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both channels at each edge; values seen here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) trim_board.take_sample(in_tdata);
      if (out_tvalid && out_tready) trim_board.check_result(out_tdata, out_tuser);
    end
  end

  // Offer one sample after a random gap and hold it until the transfer completes.
  // Keep tvalid high across back-to-back samples rather than dropping and raising it.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_window();
    foreach (window_buf[i]) send_sample(window_buf[i]);
    window_buf.delete();
  endtask

  // Receiver: stall a random number of cycles per result, with quiet stretches.
  initial begin
    int stall;
    int served;
    served = 0;
    wait (rst_n);
    forever begin
      if (served % 12 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      stall = quiet_out ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      served++;
    end
  end

  initial begin
    int      mode;
    sample_t a, b;
    sample_t pool[4];
    trim_board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Flat window at the top of the range.
    for (int i = 0; i < Window; i++) window_buf.push_back(SampleMax);
    send_window();
    // Both range extremes and nothing else: no middle samples.
    for (int i = 0; i < Window; i++) window_buf.push_back((i % 2) ? SampleMax : SampleMin);
    send_window();
    // Tied extremes and a small negative middle sum: mean truncates toward zero.
    window_buf = '{-3, 5, -1, -2, 0, -3, 5, 1, -1, 2};
    send_window();

    // Random windows; about half are shaped to hit ties, flat and extreme-only windows.
    for (int w = 0; w < RandomWindows; w++) begin
      if (w % 16 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      a    = sample_t'($urandom);
      b    = sample_t'($urandom);
      foreach (pool[k]) pool[k] = sample_t'($urandom);
      for (int i = 0; i < Window; i++) begin
        case (mode)
          0: begin
            window_buf.push_back(a);
          end
          1: begin
            window_buf.push_back($urandom_range(0, 1) ? a : b);
          end
          2, 3: begin
            window_buf.push_back(pool[$urandom_range(0, 3)]);
          end
          4: begin
            case ($urandom_range(0, 2))
              0:       window_buf.push_back(SampleMax);
              1:       window_buf.push_back(SampleMin);
              default: window_buf.push_back(a);
            endcase
          end
          default: begin
            window_buf.push_back(sample_t'($urandom));
          end
        endcase
      end
      send_window();
    end
    in_tvalid <= 1'b0;
    // Let the monitor fold in the last sample before counting what is outstanding.
    @(posedge clk);

    // Drain outstanding results, then linger to catch any stray transfer.
    while (trim_board.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (trim_board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
